// ===== rtl/core/rkat_pkg.sv =====
// Package for the recent-key accumulate table: item and result types,
// key kind codes, total limits and the stepped factor function.
// No dependencies.
package rkat_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 16;

   localparam int ID_W     = 31;
   localparam int AMOUNT_W = 16;
   localparam int FACTOR_W = 7;
   localparam int KIND_W   = 2;

   // stored kind codes; empty never matches a lookup
   localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MONSTER = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PLAYER  = 2'd2;

   localparam logic FUNC_RECORD = 1'b0;
   localparam logic FUNC_QUERY  = 1'b1;

   localparam logic [AMOUNT_W-1:0] TOTAL_MAX = 16'hFFFF;

   // factor steps, in hundredths, and the totals below which each applies
   localparam logic [AMOUNT_W-1:0] STEP_1_LIMIT = 16'd201;
   localparam logic [AMOUNT_W-1:0] STEP_2_LIMIT = 16'd301;
   localparam logic [AMOUNT_W-1:0] STEP_3_LIMIT = 16'd501;
   localparam logic [AMOUNT_W-1:0] STEP_4_LIMIT = 16'd701;
   localparam logic [AMOUNT_W-1:0] STEP_5_LIMIT = 16'd1001;

   localparam logic [FACTOR_W-1:0] FACTOR_FULL   = 7'd100;
   localparam logic [FACTOR_W-1:0] FACTOR_STEP_2 = 7'd95;
   localparam logic [FACTOR_W-1:0] FACTOR_STEP_3 = 7'd85;
   localparam logic [FACTOR_W-1:0] FACTOR_STEP_4 = 7'd65;
   localparam logic [FACTOR_W-1:0] FACTOR_STEP_5 = 7'd45;
   localparam logic [FACTOR_W-1:0] FACTOR_FLOOR  = 7'd30;

   typedef struct packed {
      logic                func;
      logic                requester_is_player;
      logic                victim_kind;
      logic [ID_W-1:0]     victim_id;
      logic [AMOUNT_W-1:0] kill_share;
   } item_type;

   typedef struct packed {
      logic                matched;
      logic [AMOUNT_W-1:0] kill_total;
      logic [FACTOR_W-1:0] xp_factor;
      logic                accepted;
   } result_type;

   function automatic logic [FACTOR_W-1:0] factor_of(input logic [AMOUNT_W-1:0] total);
      logic [FACTOR_W-1:0] f;
      if (total < STEP_1_LIMIT) begin
         f = FACTOR_FULL;
      end else if (total < STEP_2_LIMIT) begin
         f = FACTOR_STEP_2;
      end else if (total < STEP_3_LIMIT) begin
         f = FACTOR_STEP_3;
      end else if (total < STEP_4_LIMIT) begin
         f = FACTOR_STEP_4;
      end else if (total < STEP_5_LIMIT) begin
         f = FACTOR_STEP_5;
      end else begin
         f = FACTOR_FLOOR;
      end
      return f;
   endfunction

endpackage

// ===== rtl/core/rkat_table.sv =====
// Key table of the recent-key accumulate table: parallel key match,
// saturating accumulate, FIFO slot replacement and result formation.
// Depends on rkat_pkg.
module rkat_table #(
   parameter int TableDepth = rkat_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rkat_pkg::item_type    item,
   input  logic                  commit,   // item leaves for the result register
   output rkat_pkg::result_type  result
);

   localparam int SlotW = $clog2(TableDepth);
   localparam logic [SlotW-1:0] LastSlot = SlotW'(TableDepth - 1);

   logic [rkat_pkg::KIND_W-1:0]   kind_ff  [TableDepth];
   logic [rkat_pkg::ID_W-1:0]     key_ff   [TableDepth];
   logic [rkat_pkg::AMOUNT_W-1:0] total_ff [TableDepth];
   logic [SlotW-1:0]              oldest_ff, oldest_in;

   logic [rkat_pkg::KIND_W-1:0]   kind_code;
   logic                          hit;
   logic [SlotW-1:0]              hit_idx;
   logic [rkat_pkg::AMOUNT_W:0]   sum;
   logic [rkat_pkg::AMOUNT_W-1:0] sat_total;
   logic [rkat_pkg::AMOUNT_W-1:0] new_total;
   logic                          do_record;
   logic [SlotW-1:0]              wr_slot;

   assign kind_code = item.victim_kind ? rkat_pkg::KIND_PLAYER : rkat_pkg::KIND_MONSTER;

   // first matching slot wins
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = 0; i < TableDepth; i++) begin
         if (!hit && kind_ff[i] == kind_code && key_ff[i] == item.victim_id) begin
            hit     = 1'b1;
            hit_idx = SlotW'(i);
         end
      end
   end

   assign sum       = {1'b0, total_ff[hit_idx]} + {1'b0, item.kill_share};
   assign sat_total = sum[rkat_pkg::AMOUNT_W] ? rkat_pkg::TOTAL_MAX
                                              : sum[rkat_pkg::AMOUNT_W-1:0];
   assign do_record = commit && item.requester_is_player
                      && (item.func == rkat_pkg::FUNC_RECORD);
   assign wr_slot   = hit ? hit_idx : oldest_ff;

   always_comb begin
      if (item.func == rkat_pkg::FUNC_RECORD) begin
         new_total = hit ? sat_total : item.kill_share;
      end else begin
         new_total = hit ? total_ff[hit_idx] : '0;
      end
   end

   always_comb begin
      if (item.requester_is_player) begin
         result.matched    = hit;
         result.kill_total = new_total;
         result.xp_factor  = rkat_pkg::factor_of(new_total);
         result.accepted   = 1'b1;
      end else begin
         result.matched    = 1'b0;
         result.kill_total = '0;
         result.xp_factor  = rkat_pkg::FACTOR_FULL;
         result.accepted   = 1'b0;
      end
   end

   // advance the replacement pointer on every miss that records
   always_comb begin
      oldest_in = oldest_ff;
      if (do_record && !hit) begin
         oldest_in = (oldest_ff == LastSlot) ? '0 : oldest_ff + SlotW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff <= '0;
         for (int i = 0; i < TableDepth; i++) begin
            kind_ff[i] <= rkat_pkg::KIND_EMPTY;
         end
      end else begin
         oldest_ff <= oldest_in;
         if (do_record && !hit) begin
            kind_ff[wr_slot] <= kind_code;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_record) begin
         key_ff[wr_slot]   <= item.victim_id;
         total_ff[wr_slot] <= new_total;
      end
   end

endmodule

// ===== rtl/core/recent_key_accumulate_table_top.sv =====
// Top level of the recent-key accumulate table: stream handshake, input
// register and result register around the key table.
// Depends on rkat_pkg and rkat_table.
//
// Usage:
//   req_* carries one item per transfer: a record adds kill_share to the
//   entry for (victim_kind, victim_id), claiming the oldest slot on a miss;
//   a query returns the stored total and the stepped factor. Items whose
//   requester is not a player leave the table untouched and return
//   accepted 0.
//   rsp_* returns exactly one result per item, in order.
//   rsp_tvalid rises once the item has passed the input register, then the
//   result register. Throughput: one item per cycle while results are taken;
//   the table lookup and update sit between the two registers, so each item
//   sees the table as left by the one before.
//   Reset: synchronous, active high. Clears all slots to empty, the
//   replacement pointer to slot 0 and both pipeline valid flags.
//   Stall: when rsp_tready is low, the result register holds, the input
//   register still takes one more item, and then req_tready drops until
//   the result is taken.
module recent_key_accumulate_table_top #(
   parameter int TableDepth = rkat_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // victim_id[30:0], kill_share[46:31], zero[47]
   input  logic [2:0]  req_tuser,   // func[0], requester_is_player[1], victim_kind[2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // kill_total[15:0], xp_factor[22:16], zero[23]
   output logic [1:0]  rsp_tuser    // matched[0], accepted[1]
);

   logic                 s1_valid_ff, s1_valid_in;
   rkat_pkg::item_type   s1_item_ff, s1_item_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rkat_pkg::result_type rsp_result_ff, rsp_result_in;
   rkat_pkg::item_type   req_item;
   logic                 advance;
   logic                 commit;
   rkat_pkg::result_type table_result;

   // unpack the request transfer
   assign req_item.func                = req_tuser[0];
   assign req_item.requester_is_player = req_tuser[1];
   assign req_item.victim_kind         = req_tuser[2];
   assign req_item.victim_id           = req_tdata[30:0];
   assign req_item.kill_share          = req_tdata[46:31];

   // result register empties or is taken this cycle
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign commit     = s1_valid_ff && advance;
   assign req_tready = !s1_valid_ff || advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (req_tready) begin
         s1_valid_in = req_tvalid;
         s1_item_in  = req_item;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      if (advance) begin
         rsp_valid_in  = s1_valid_ff;
         rsp_result_in = table_result;
      end
   end

   rkat_table #(
      .TableDepth(TableDepth)
   ) u_table (
      .clock  (clock),
      .reset  (reset),
      .item   (s1_item_ff),
      .commit (commit),
      .result (table_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      s1_item_ff    <= s1_item_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_result_ff.xp_factor, rsp_result_ff.kill_total};
   assign rsp_tuser  = {rsp_result_ff.accepted, rsp_result_ff.matched};

endmodule
